// ===== design/assert_macros.svh =====
// Assertion helpers used by the parser design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mmp_pkg.sv =====
`default_nettype none

package mmp_pkg;

  // status byte codes
  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_END     = 8'hF7;
  localparam logic [7:0] REALTIME_MIN  = 8'hF8;
  localparam logic [3:0] PROG_CHANGE   = 4'hC;
  localparam logic [3:0] CHAN_PRESSURE = 4'hD;
  localparam logic [3:0] SYSTEM_NIB    = 4'hF;
  localparam logic [7:0] MTC_QUARTER   = 8'hF1;
  localparam logic [7:0] SONG_POSITION = 8'hF2;
  localparam logic [7:0] SONG_SELECT   = 8'hF3;
  localparam logic [7:0] NO_STATUS     = 8'h00;

  // result payload, last field lowest
  typedef struct packed {
    logic [31:0] msg_total;
    logic [6:0]  msg_data2;
    logic [6:0]  msg_data1;
    logic [7:0]  msg_status;
  } msg_t;

  // number of data bytes a status byte takes
  function automatic logic [1:0] data_count(input logic [7:0] st);
    logic [1:0] cnt;
    if (st >= REALTIME_MIN) begin
      cnt = 2'd0;
    end else if (st == MTC_QUARTER || st == SONG_SELECT) begin
      cnt = 2'd1;
    end else if (st == SONG_POSITION) begin
      cnt = 2'd2;
    end else if (st[7:4] == SYSTEM_NIB) begin
      cnt = 2'd0;
    end else if (st[7:4] == PROG_CHANGE || st[7:4] == CHAN_PRESSURE) begin
      cnt = 2'd1;
    end else begin
      cnt = 2'd2;
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

// ===== design/midi_message_parser_unit.sv =====
`default_nettype none

`include "assert_macros.svh"

// MIDI message parser with running status. Takes one received MIDI byte per
// item and gives one item per completed message: status, up to two data
// bytes and a wrapping 32-bit count of completed messages. Realtime bytes
// are dropped, system exclusive blocks are skipped and a completed system
// message cancels running status. One byte can be accepted every cycle
// while results are taken; a byte passes through an input register, is
// parsed combinationally against the state and its result lands in the
// output register. The input register lets one further byte in while a
// result waits to be taken.
module midi_message_parser_unit
  import mmp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] rx_byte
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: [7:0] msg_status, [14:8] msg_data1, [21:15] msg_data2,
  //            [53:22] msg_total, [55:54] zero
  output logic [55:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  // input stage
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // parser state
  logic [7:0]  rs_r,      rs_nxt;
  logic [1:0]  needed_r,  needed_nxt;
  logic [1:0]  got_r,     got_nxt;
  logic [6:0]  hold0_r,   hold0_nxt;
  logic [6:0]  hold1_r,   hold1_nxt;
  logic        sysex_r,   sysex_nxt;
  logic [31:0] counter_r, counter_nxt;

  // output stage
  logic        out_valid_r;
  msg_t        out_msg_r;
  msg_t        msg_nxt;

  logic emit_w;
  logic take_w;
  logic advance_w;
  logic in_accept_w;

  assign advance_w   = !out_valid_r || out_tready;
  assign take_w      = in_valid_r && advance_w;
  assign in_tready   = !in_valid_r || advance_w;
  assign in_accept_w = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_msg_r};

  // parse the held byte against the current state
  always_comb begin
    logic [7:0] b;
    logic       go;
    b           = in_byte_r;
    go          = 1'b0;
    rs_nxt      = rs_r;
    needed_nxt  = needed_r;
    got_nxt     = got_r;
    hold0_nxt   = hold0_r;
    hold1_nxt   = hold1_r;
    sysex_nxt   = sysex_r;
    counter_nxt = counter_r;
    emit_w      = 1'b0;
    msg_nxt     = '0;

    if (b >= REALTIME_MIN) begin
      go = 1'b0;
    end else if (b[7]) begin
      if (b == SYSEX_START) begin
        sysex_nxt  = 1'b1;
        rs_nxt     = NO_STATUS;
        needed_nxt = 2'd0;
        got_nxt    = 2'd0;
      end else if (b == SYSEX_END) begin
        sysex_nxt = 1'b0;
      end else if (!sysex_r) begin
        rs_nxt     = b;
        needed_nxt = data_count(b);
        got_nxt    = 2'd0;
        if (needed_nxt == 2'd0) begin
          // message without data completes at once
          rs_nxt             = NO_STATUS;
          emit_w             = 1'b1;
          msg_nxt.msg_status = b;
        end
      end
    end else if (!sysex_r) begin
      go = 1'b1;
      // start a new group under running status
      if (needed_nxt == 2'd0) begin
        if (rs_nxt == NO_STATUS) begin
          go = 1'b0;
        end else begin
          needed_nxt = data_count(rs_nxt);
          got_nxt    = 2'd0;
          if (needed_nxt == 2'd0) begin
            rs_nxt = NO_STATUS;
            go     = 1'b0;
          end
        end
      end
      if (go) begin
        if (got_nxt == 2'd0) begin
          hold0_nxt = b[6:0];
        end else if (got_nxt == 2'd1) begin
          hold1_nxt = b[6:0];
        end
        got_nxt = got_nxt + 2'd1;
        if (got_nxt >= needed_nxt) begin
          emit_w             = 1'b1;
          msg_nxt.msg_status = rs_nxt;
          msg_nxt.msg_data1  = hold0_nxt;
          msg_nxt.msg_data2  = (needed_nxt > 2'd1) ? hold1_nxt : 7'd0;
          if (rs_nxt[7:4] == SYSTEM_NIB) begin
            rs_nxt = NO_STATUS;
          end
          needed_nxt = 2'd0;
          got_nxt    = 2'd0;
        end
      end
    end

    if (emit_w) begin
      counter_nxt = counter_r + 32'd1;
    end
    msg_nxt.msg_total = counter_nxt;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept_w) begin
      in_valid_r <= 1'b1;
    end else if (advance_w) begin
      in_valid_r <= 1'b0;
    end
    if (in_accept_w) begin
      in_byte_r <= in_tdata;
    end
  end

  // parser state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r      <= NO_STATUS;
      needed_r  <= 2'd0;
      got_r     <= 2'd0;
      hold0_r   <= 7'd0;
      hold1_r   <= 7'd0;
      sysex_r   <= 1'b0;
      counter_r <= 32'd0;
    end else if (take_w) begin
      rs_r      <= rs_nxt;
      needed_r  <= needed_nxt;
      got_r     <= got_nxt;
      hold0_r   <= hold0_nxt;
      hold1_r   <= hold1_nxt;
      sysex_r   <= sysex_nxt;
      counter_r <= counter_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance_w) begin
      out_valid_r <= take_w && emit_w;
    end
    if (take_w && emit_w) begin
      out_msg_r <= msg_nxt;
    end
  end

  // checks
  `ASSERT_ALWAYS(a_sysex_no_status, !sysex_r || rs_r == NO_STATUS, "running status inside sysex")
  `ASSERT_ALWAYS(a_partial, got_r == 2'd0 || (got_r == 2'd1 && needed_r == 2'd2), "bad partial")
  `ASSERT_NEXT(a_count_step, take_w && emit_w, counter_r == $past(counter_r) + 32'd1, "count slip")
  `ASSERT_NEXT(a_result_loaded, take_w && emit_w, out_valid_r, "completed message lost")

endmodule

`default_nettype wire
